>>> hdl/efws_pkg.sv
`timescale 1ns / 1ps

package efws_pkg;

  // Built capacity and time width
  localparam int MAX_WORKERS = 16;
  localparam int TIME_BITS   = 48;

  // Fixed field widths
  localparam int DUR_W   = 32;
  localparam int WIDX_W  = 4;
  localparam int START_W = 48;
  localparam int CFG_W   = 5;

  localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int COUNT_W = $clog2(MAX_WORKERS + 1);

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [COUNT_W-1:0] RESET_COUNT =
    COUNT_W'((MAX_WORKERS < 16) ? MAX_WORKERS : 16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } efws_state_e;

  // zero means one worker, anything above capacity means all of them
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [COUNT_W-1:0] c;
    if (v == '0) begin
      c = COUNT_W'(1);
    end else if (int'(v) > MAX_WORKERS) begin
      c = COUNT_W'(MAX_WORKERS);
    end else begin
      c = COUNT_W'(v);
    end
    return c;
  endfunction

endpackage

>>> hdl/efws_job_if.sv
`timescale 1ns / 1ps

interface efws_job_if;
  logic                         valid;
  logic                         ready;
  logic [efws_pkg::DUR_W-1:0]   job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink   (input valid, input job_duration, output ready);
endinterface

>>> hdl/efws_res_if.sv
`timescale 1ns / 1ps

interface efws_res_if;
  logic                          valid;
  logic                          ready;
  logic [efws_pkg::WIDX_W-1:0]   worker_index;
  logic [efws_pkg::START_W-1:0]  start_time;

  modport source (output valid, output worker_index, output start_time, input ready);
  modport sink   (input valid, input worker_index, input start_time, output ready);
endinterface

>>> hdl/earliest_free_worker_job_scheduler_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                          Transfer
// job_i    in   job_duration[31:0]               valid & ready
// res_o    out  worker_index[3:0], start_time    valid & ready
// cfg      in   cfg_wdata_i[4:0] (worker count)  cfg_we_i
//
// With n workers in use an item runs through taking the job, n-1 compare
// steps of the single comparator walking the free times, and one write.
// job_i.ready is high only while idle; a finished result sits in the output
// register, so the next job is taken while it waits.
// A stalled output holds the final write step until the register frees.
// Reset (async, low) and any config write clear every free time at once.

module earliest_free_worker_job_scheduler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [efws_pkg::CFG_W-1:0]    cfg_wdata_i,
  efws_job_if.sink                      job_i,
  efws_res_if.source                    res_o
);

  localparam int TB = efws_pkg::TIME_BITS;
  localparam int IW = efws_pkg::IDX_W;

  efws_pkg::efws_state_e state_q, state_d;

  logic [TB-1:0]                   heap_q [efws_pkg::MAX_WORKERS];
  logic [efws_pkg::COUNT_W-1:0]    heap_size_q;
  logic [efws_pkg::DUR_W-1:0]      dur_q;
  logic [IW-1:0]                   scan_idx_q;
  logic [IW-1:0]                   best_idx_q;
  logic [TB-1:0]                   best_val_q;

  logic                            res_valid_q;
  logic [efws_pkg::WIDX_W-1:0]     res_idx_q;
  logic [efws_pkg::START_W-1:0]    res_start_q;

  logic          in_xfer;
  logic          job_ready;
  logic          scan_en;
  logic          write_en;
  logic          single;
  logic          scan_last;
  logic [TB-1:0] cand;
  logic [TB:0]   sum;
  logic [TB-1:0] fin;

  assign in_xfer   = job_i.valid && job_ready;
  assign single    = (heap_size_q == efws_pkg::COUNT_W'(1));
  assign scan_last = (scan_idx_q == IW'(heap_size_q - efws_pkg::COUNT_W'(1)));
  assign cand      = heap_q[scan_idx_q];
  assign sum       = {1'b0, best_val_q} + (TB + 1)'(dur_q);
  assign fin       = sum[TB] ? efws_pkg::TIME_MAX : sum[TB-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      efws_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = single ? efws_pkg::ST_WRITE : efws_pkg::ST_SCAN;
        end
      end
      efws_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = efws_pkg::ST_WRITE;
        end
      end
      efws_pkg::ST_WRITE: begin
        if (write_en) begin
          state_d = efws_pkg::ST_IDLE;
        end
      end
      default: state_d = efws_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_ready = 1'b0;
    scan_en   = 1'b0;
    write_en  = 1'b0;
    case (state_q)
      efws_pkg::ST_IDLE:  job_ready = 1'b1;
      efws_pkg::ST_SCAN:  scan_en   = 1'b1;
      efws_pkg::ST_WRITE: write_en  = !res_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efws_pkg::ST_IDLE;
      heap_size_q <= efws_pkg::RESET_COUNT;
      res_valid_q <= 1'b0;
      for (int i = 0; i < efws_pkg::MAX_WORKERS; i++) begin
        heap_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        heap_size_q <= efws_pkg::clamp_count(cfg_wdata_i);
        for (int i = 0; i < efws_pkg::MAX_WORKERS; i++) begin
          heap_q[i] <= '0;
        end
      end else if (write_en) begin
        heap_q[best_idx_q] <= fin;
      end
      if (write_en) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dur_q      <= job_i.job_duration;
      best_idx_q <= '0;
      best_val_q <= heap_q[0];
      scan_idx_q <= IW'(1);
    end else if (scan_en) begin
      // strict less-than keeps the lowest index on a tie
      if (cand < best_val_q) begin
        best_idx_q <= scan_idx_q;
        best_val_q <= cand;
      end
      scan_idx_q <= scan_idx_q + IW'(1);
    end
    if (write_en) begin
      res_idx_q   <= efws_pkg::WIDX_W'(best_idx_q);
      res_start_q <= efws_pkg::START_W'(best_val_q);
    end
  end

  assign job_i.ready        = job_ready;
  assign res_o.valid        = res_valid_q;
  assign res_o.worker_index = res_idx_q;
  assign res_o.start_time   = res_start_q;

endmodule

>>> hdl/efws_checker.sv
`timescale 1ns / 1ps

module efws_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  logic                          job_ready_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [efws_pkg::WIDX_W-1:0]   res_worker_index_i,
  input  logic [efws_pkg::START_W-1:0]  res_start_time_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_q, pending_d;

  assign in_xfer  = job_valid_i && job_ready_i;
  assign out_xfer = res_valid_i && res_ready_i;

  // jobs taken but not yet delivered
  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_worker_index_i)
      && $stable(res_start_time_i))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !job_ready_i)
    else $error("job taken while the previous one is still in work");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pending_q != 2'd0)
    else $error("result shown with no job outstanding");

  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_ready_i |-> pending_q != 2'd0)
    else $error("input stalled with nothing in work");

endmodule

bind earliest_free_worker_job_scheduler_core efws_checker u_efws_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .job_valid_i        (job_i.valid),
  .job_ready_i        (job_i.ready),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_worker_index_i (res_o.worker_index),
  .res_start_time_i   (res_o.start_time)
);
